### src/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg: shared types and constants of the buffer cache LRU core
// Slot count, field widths, request and result codes, command struct.
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int unsigned Slots     = 32;
  localparam int unsigned SlotW     = $clog2(Slots);
  localparam int unsigned LenW      = $clog2(Slots + 1);
  localparam int unsigned CountBits = 8;
  localparam int unsigned BlockW    = 32;
  localparam int unsigned AddrW     = 35;
  localparam int unsigned SpbW      = 4;

  localparam logic [2:0] KindAcquire = 3'd0;
  localparam logic [2:0] KindDirty   = 3'd1;
  localparam logic [2:0] KindRelease = 3'd2;
  localparam logic [2:0] KindSync    = 3'd3;
  localparam logic [2:0] KindDrop    = 3'd4;

  localparam logic [1:0] ActWriteback = 2'd0;
  localparam logic [1:0] ActFetch     = 2'd1;
  localparam logic [1:0] ActComplete  = 2'd2;

  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatNoBuf   = 2'd1;
  localparam logic [1:0] StatStorage = 2'd2;

  localparam logic [SpbW-1:0] SpbReset = 4'd2;

  typedef struct packed {
    logic [2:0]        kind;
    logic [BlockW-1:0] block_number;
    logic [4:0]        slot;
    logic [31:0]       writeback_fail_mask;
    logic              fetch_fail;
  } req_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [4:0]        result_slot;
    logic [BlockW-1:0] result_block;
    logic [AddrW-1:0]  sector_address;
    logic [SpbW-1:0]   sector_count;
    logic [1:0]        status;
    logic              hit;
    logic              last;
  } rsp_t;

  // controller -> datapath commands
  typedef enum logic [3:0] {
    OpNone, OpLatch, OpHitScan, OpHitApply, OpLruScan, OpLruWb, OpFetch,
    OpSimple, OpSyncSlot, OpDropSlot, OpMissDone, OpSyncDone, OpLruLoad
  } op_e;

  typedef struct packed {
    op_e op;
    logic emit;   // load output register with the formed result
  } cmd_t;

  typedef struct packed {
    logic hit_found;     // hit located
    logic scan_end;      // scan pointer past end
    logic cand_dirty;    // current candidate dirty
    logic cand_fail;     // current candidate write-back fails
    logic victim_found;
    logic [2:0] kind;
  } sts_t;

endpackage

### src/bbc_if.sv
// ----------------------------------------------------------------------------
// bbc_if: valid/ready channel carrying one payload
// Source drives valid and payload, sink drives ready.
// ----------------------------------------------------------------------------
interface bbc_if #(type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### src/bbc_ctrl.sv
// ----------------------------------------------------------------------------
// bbc_ctrl: request sequencer
// Walks the datapath through hit search, victim scan, dirty/release updates, sync and drop sweeps.
// ----------------------------------------------------------------------------
module bbc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 out_full_i,
  input  bbc_pkg::sts_t        sts_i,
  output bbc_pkg::cmd_t        cmd_o
);

  typedef enum logic [3:0] {
    StIdle, StHit, StHitApply, StLoad, StScan, StFetch, StMissDone,
    StSimple, StSync, StDrop, StSyncDone
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '{op: bbc_pkg::OpNone, emit: 1'b0};
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.op = bbc_pkg::OpLatch;
          state_d  = StHit;
        end
      end
      StHit: begin
        // dispatch on kind, or scan tags for an acquire
        if (sts_i.kind == bbc_pkg::KindAcquire) begin
          if (sts_i.hit_found) begin
            state_d = StHitApply;
          end else if (sts_i.scan_end) begin
            cmd_o.op = bbc_pkg::OpLruLoad;
            state_d  = StLoad;
          end else begin
            cmd_o.op = bbc_pkg::OpHitScan;
          end
        end else if (sts_i.kind == bbc_pkg::KindDirty ||
                     sts_i.kind == bbc_pkg::KindRelease) begin
          state_d = StSimple;
        end else if (sts_i.kind == bbc_pkg::KindSync ||
                     sts_i.kind == bbc_pkg::KindDrop) begin
          cmd_o.op = bbc_pkg::OpLruLoad;
          state_d  = StSync;
        end else begin
          state_d = StIdle;
        end
      end
      StHitApply: begin
        if (!out_full_i) begin
          cmd_o   = '{op: bbc_pkg::OpHitApply, emit: 1'b1};
          state_d = StIdle;
        end
      end
      StLoad: state_d = StScan;
      StScan: begin
        if (sts_i.victim_found) begin
          state_d = StFetch;
        end else if (sts_i.scan_end) begin
          state_d = StMissDone;
        end else if (!sts_i.cand_dirty) begin
          cmd_o.op = bbc_pkg::OpLruScan;
        end else if (!out_full_i) begin
          cmd_o = '{op: bbc_pkg::OpLruWb, emit: 1'b1};
        end
      end
      StFetch: begin
        if (!out_full_i) begin
          cmd_o   = '{op: bbc_pkg::OpFetch, emit: 1'b1};
          state_d = StMissDone;
        end
      end
      StMissDone, StSyncDone: begin
        if (!out_full_i) begin
          cmd_o   = '{op: (state_q == StMissDone) ? bbc_pkg::OpMissDone
                                                  : bbc_pkg::OpSyncDone,
                      emit: 1'b1};
          state_d = StIdle;
        end
      end
      StSimple: begin
        if (!out_full_i) begin
          cmd_o   = '{op: bbc_pkg::OpSimple, emit: 1'b1};
          state_d = StIdle;
        end
      end
      StSync: begin
        if (sts_i.scan_end) begin
          state_d = (sts_i.kind == bbc_pkg::KindDrop) ? StDrop : StSyncDone;
          cmd_o.op = bbc_pkg::OpLruLoad;
        end else if (!sts_i.cand_dirty) begin
          cmd_o.op = bbc_pkg::OpSyncSlot;
        end else if (!out_full_i) begin
          cmd_o = '{op: bbc_pkg::OpSyncSlot, emit: 1'b1};
        end
      end
      StDrop: begin
        if (sts_i.scan_end) begin
          state_d = StSyncDone;
        end else begin
          cmd_o.op = bbc_pkg::OpDropSlot;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### src/bbc_dp.sv
// ----------------------------------------------------------------------------
// bbc_dp: tags, counts, LRU list and result formation
// One slot is examined per cycle through a shared scan pointer, unless a full result register holds the scan.
// ----------------------------------------------------------------------------
module bbc_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bbc_pkg::req_t                   req_i,
  input  logic [bbc_pkg::SpbW-1:0]        spb_i,
  input  bbc_pkg::cmd_t                   cmd_i,
  output bbc_pkg::sts_t                   sts_o,
  output bbc_pkg::rsp_t                   rsp_o
);

  localparam int unsigned SW = bbc_pkg::SlotW;
  localparam int unsigned LW = bbc_pkg::LenW;
  localparam int unsigned CW = bbc_pkg::CountBits;
  localparam logic [CW-1:0] CMax = '1;

  logic [bbc_pkg::BlockW-1:0] tag_q   [bbc_pkg::Slots];
  logic [CW-1:0]              cnt_q   [bbc_pkg::Slots];
  logic [SW-1:0]              lru_q   [bbc_pkg::Slots];
  logic [bbc_pkg::Slots-1:0]  valid_q, dirty_q;
  logic [LW-1:0]              len_q;
  bbc_pkg::req_t              req_q;
  logic [LW-1:0]              ptr_q;      // scan index
  logic [SW-1:0]              hit_slot_q;
  logic                       hit_q, vic_q, bad_q;
  logic                       lru_scan_q; // pointer walks the LRU list
  logic [SW-1:0]              vic_slot_q;

  logic [SW-1:0] ps, cand;
  logic          ptr_end;
  logic [SW-1:0] rem_slot;
  logic          do_rem, do_app;
  logic [SW-1:0] app_slot;
  logic [LW-1:0] rem_pos;
  logic          rem_hit;
  logic [SW-1:0] tail_idx;
  logic [bbc_pkg::BlockW-1:0] cmd_blk;
  logic [bbc_pkg::AddrW-1:0]  addr;
  logic          simple_ok;
  logic [SW-1:0] req_s;

  assign ps      = ptr_q[SW-1:0];
  assign ptr_end = (ptr_q >= (lru_scan_q ? len_q : LW'(bbc_pkg::Slots)));
  assign cand    = lru_q[ps];
  assign req_s   = req_q.slot[SW-1:0];
  assign simple_ok = (32'(req_q.slot) < bbc_pkg::Slots);
  assign tail_idx  = SW'(len_q - 1'b1);

  // position of the slot to remove (one independent compare per entry)
  always_comb begin
    rem_pos = '0;
    rem_hit = 1'b0;
    for (int i = bbc_pkg::Slots - 1; i >= 0; i--) begin
      if (LW'(i) < len_q && lru_q[i] == rem_slot) begin
        rem_pos = LW'(i);
        rem_hit = 1'b1;
      end
    end
  end

  always_comb begin
    sts_o.hit_found    = hit_q;
    sts_o.scan_end     = ptr_end;
    sts_o.cand_dirty   = 1'b0;
    sts_o.cand_fail    = 1'b0;
    sts_o.victim_found = vic_q;
    sts_o.kind         = req_q.kind;
    if (req_q.kind == bbc_pkg::KindAcquire) begin
      sts_o.cand_dirty = !ptr_end && dirty_q[cand];
      sts_o.cand_fail  = req_q.writeback_fail_mask[cand];
    end else begin
      sts_o.cand_dirty = !ptr_end && dirty_q[ps];
      sts_o.cand_fail  = req_q.writeback_fail_mask[ps];
    end
  end

  // remove/append control
  always_comb begin
    do_rem   = 1'b0;
    rem_slot = hit_slot_q;
    do_app   = 1'b0;
    app_slot = vic_slot_q;
    case (cmd_i.op)
      bbc_pkg::OpHitApply: do_rem = (cnt_q[hit_slot_q] == '0);
      bbc_pkg::OpFetch: begin
        do_rem   = 1'b1;
        rem_slot = vic_slot_q;
        do_app   = req_q.fetch_fail;
      end
      bbc_pkg::OpSimple: begin
        app_slot = req_s;
        do_app   = simple_ok && req_q.kind == bbc_pkg::KindRelease &&
                   cnt_q[req_s] == CW'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    cmd_blk = req_q.block_number;
    if (cmd_i.op == bbc_pkg::OpLruWb) cmd_blk = tag_q[cand];
    if (cmd_i.op == bbc_pkg::OpSyncSlot) cmd_blk = tag_q[ps];
  end
  assign addr = bbc_pkg::AddrW'(cmd_blk) * bbc_pkg::AddrW'(spb_i);

  // result register: loaded only on emit, held while the sink stalls
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      rsp_o.result_block   <= cmd_blk;
      rsp_o.sector_address <= addr;
      rsp_o.sector_count   <= spb_i;
      rsp_o.hit            <= 1'b0;
      rsp_o.last           <= 1'b0;
      rsp_o.status         <= bbc_pkg::StatOk;
      rsp_o.action         <= bbc_pkg::ActWriteback;
      rsp_o.result_slot    <= 5'(ps);
      case (cmd_i.op)
        bbc_pkg::OpLruWb: begin
          rsp_o.result_slot <= 5'(cand);
          rsp_o.status <= sts_o.cand_fail ? bbc_pkg::StatStorage : bbc_pkg::StatOk;
        end
        bbc_pkg::OpSyncSlot: begin
          rsp_o.status <= sts_o.cand_fail ? bbc_pkg::StatStorage : bbc_pkg::StatOk;
        end
        bbc_pkg::OpFetch: begin
          rsp_o.action      <= bbc_pkg::ActFetch;
          rsp_o.result_slot <= 5'(vic_slot_q);
          rsp_o.status <= req_q.fetch_fail ? bbc_pkg::StatStorage : bbc_pkg::StatOk;
        end
        default: begin
          rsp_o.action         <= bbc_pkg::ActComplete;
          rsp_o.last           <= 1'b1;
          rsp_o.sector_address <= '0;
          rsp_o.sector_count   <= '0;
          case (cmd_i.op)
            bbc_pkg::OpHitApply: begin
              rsp_o.hit         <= 1'b1;
              rsp_o.result_slot <= 5'(hit_slot_q);
            end
            bbc_pkg::OpMissDone: begin
              if (!vic_q) begin
                rsp_o.result_slot <= '0;
                rsp_o.status      <= bbc_pkg::StatNoBuf;
              end else begin
                rsp_o.result_slot <= 5'(vic_slot_q);
                rsp_o.status <= req_q.fetch_fail ? bbc_pkg::StatStorage
                                                 : bbc_pkg::StatOk;
              end
            end
            bbc_pkg::OpSimple: begin
              rsp_o.result_slot  <= req_q.slot;
              rsp_o.result_block <= simple_ok ? tag_q[req_s] : '0;
            end
            default: begin
              rsp_o.result_slot  <= '0;
              rsp_o.result_block <= '0;
              rsp_o.status <= bad_q ? bbc_pkg::StatStorage : bbc_pkg::StatOk;
            end
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
      len_q   <= LW'(bbc_pkg::Slots);
      for (int i = 0; i < bbc_pkg::Slots; i++) begin
        tag_q[i] <= '0;
        cnt_q[i] <= '0;
        lru_q[i] <= SW'(i);
      end
      ptr_q <= '0; hit_q <= 1'b0; vic_q <= 1'b0; bad_q <= 1'b0;
      lru_scan_q <= 1'b0;
      hit_slot_q <= '0; vic_slot_q <= '0;
    end else begin
      case (cmd_i.op)
        bbc_pkg::OpLatch: begin
          ptr_q <= '0; hit_q <= 1'b0; vic_q <= 1'b0; bad_q <= 1'b0;
          lru_scan_q <= 1'b0;
        end
        bbc_pkg::OpHitScan: begin
          if (valid_q[ps] && tag_q[ps] == req_q.block_number) begin
            hit_q      <= 1'b1;
            hit_slot_q <= ps;
          end else begin
            ptr_q <= ptr_q + 1'b1;
          end
        end
        bbc_pkg::OpLruLoad: begin
          ptr_q      <= '0;
          lru_scan_q <= (req_q.kind == bbc_pkg::KindAcquire);
        end
        bbc_pkg::OpHitApply: begin
          if (cnt_q[hit_slot_q] != CMax) cnt_q[hit_slot_q] <= cnt_q[hit_slot_q] + 1'b1;
        end
        bbc_pkg::OpLruScan: begin
          vic_q <= 1'b1; vic_slot_q <= cand;
        end
        bbc_pkg::OpLruWb: begin
          if (sts_o.cand_fail) begin
            ptr_q <= ptr_q + 1'b1;
          end else begin
            dirty_q[cand] <= 1'b0;
            vic_q <= 1'b1; vic_slot_q <= cand;
          end
        end
        bbc_pkg::OpFetch: begin
          dirty_q[vic_slot_q] <= 1'b0;
          valid_q[vic_slot_q] <= !req_q.fetch_fail;
          if (!req_q.fetch_fail) begin
            tag_q[vic_slot_q] <= req_q.block_number;
            cnt_q[vic_slot_q] <= CW'(1);
          end
        end
        bbc_pkg::OpSimple: begin
          if (simple_ok) begin
            if (req_q.kind == bbc_pkg::KindDirty) begin
              if (valid_q[req_s]) dirty_q[req_s] <= 1'b1;
            end else if (cnt_q[req_s] != '0) begin
              cnt_q[req_s] <= cnt_q[req_s] - 1'b1;
            end
          end
        end
        bbc_pkg::OpSyncSlot: begin
          ptr_q <= ptr_q + 1'b1;
          if (dirty_q[ps]) begin
            if (sts_o.cand_fail) bad_q <= 1'b1;
            else dirty_q[ps] <= 1'b0;
          end
        end
        bbc_pkg::OpDropSlot: begin
          ptr_q <= ptr_q + 1'b1;
          if (cnt_q[ps] == '0) begin
            valid_q[ps] <= 1'b0; dirty_q[ps] <= 1'b0; tag_q[ps] <= '0;
          end
        end
        default: ;
      endcase
      // list maintenance: remove shifts the tail down, append writes the end
      if (do_rem && rem_hit) begin
        for (int i = 0; i < bbc_pkg::Slots - 1; i++) begin
          if (LW'(i) >= rem_pos && LW'(i + 1) < len_q) lru_q[i] <= lru_q[i + 1];
        end
        if (do_app) lru_q[tail_idx] <= app_slot;
        else len_q <= len_q - 1'b1;
      end else if (do_app && len_q < LW'(bbc_pkg::Slots)) begin
        lru_q[len_q[SW-1:0]] <= app_slot;
        len_q <= len_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == bbc_pkg::OpLatch) req_q <= req_i;
  end

endmodule

### src/block_buffer_cache_lru_core.sv
// Sequence from accept to result: mark dirty/release latch, dispatch and emit;
// acquire hit scans tags (one tag per cycle), then applies; acquire miss scans all
// tags, walks the LRU list, fetches into any victim found; sync sweeps; drop sweeps twice.
// One request at a time: the next is taken the cycle after its completion.
// Each result sits in an output register until taken, stalling the sequencer.
// Reset: asynchronous, clears tags, counts, flags, LRU list to 0..31, spb 2.
// ----------------------------------------------------------------------------
// block_buffer_cache_lru_core: buffer cache tag/refcount/LRU controller
// Top level joining sequencer, datapath and output register.
// ----------------------------------------------------------------------------
module block_buffer_cache_lru_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  bbc_if.sink                         req_if,
  bbc_if.source                       rsp_if,
  input  logic                        cfg_we_i,
  input  logic [bbc_pkg::SpbW-1:0]    cfg_wdata_i
);

  logic [bbc_pkg::SpbW-1:0] spb_q;
  logic                     out_v_q;
  logic                     in_ready;
  bbc_pkg::cmd_t            cmd;
  bbc_pkg::sts_t            sts;
  bbc_pkg::rsp_t            rsp;

  bbc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (req_if.valid),
    .in_ready_o (in_ready),
    .out_full_i (out_v_q && !rsp_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bbc_dp u_dp (
    .clk_i, .rst_ni,
    .req_i  (req_if.payload),
    .spb_i  (spb_q),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (rsp)
  );

  assign req_if.ready   = in_ready;
  assign rsp_if.valid   = out_v_q;
  assign rsp_if.payload = rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spb_q   <= bbc_pkg::SpbReset;
      out_v_q <= 1'b0;
    end else begin
      if (cfg_we_i) spb_q <= cfg_wdata_i;
      if (cmd.emit) out_v_q <= 1'b1;
      else if (rsp_if.ready) out_v_q <= 1'b0;
    end
  end

  a_emit_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_v_q || rsp_if.ready))
    else $error("result register overwritten");
  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !req_if.ready)
    else $error("request accepted while emitting");

endmodule

### tb/bbc_tb_if.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bbc_tb_if: testbench-side note
// The channel interface itself comes from the RTL sources (bbc_if).
// This file only holds the request builder helpers shared by the bench.
// ----------------------------------------------------------------------------
package bbc_tb_pkg;

  function automatic bbc_pkg::req_t make_req(logic [2:0] kind, logic [31:0] blk,
                                             logic [4:0] slot, logic [31:0] mask,
                                             logic ffail);
    bbc_pkg::req_t r;
    r.kind = kind;
    r.block_number = blk;
    r.slot = slot;
    r.writeback_fail_mask = mask;
    r.fetch_fail = ffail;
    return r;
  endfunction
endpackage

### tb/block_buffer_cache_lru_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_buffer_cache_lru_checker: cache state predictor and result scoreboard
// Mirrors tags, counts, dirty flags and the LRU list; checks every result.
// ----------------------------------------------------------------------------
module block_buffer_cache_lru_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     req_fire_i,
  input  bbc_pkg::req_t            req_i,
  input  logic                     rsp_fire_i,
  input  bbc_pkg::rsp_t            rsp_i,
  input  logic                     cfg_we_i,
  input  logic [bbc_pkg::SpbW-1:0] cfg_wdata_i,
  output int                       errors_o,
  output int                       pending_o,
  output int                       results_o
);
  logic [31:0]                   tags   [bbc_pkg::Slots];
  logic                          valid_q[bbc_pkg::Slots];
  logic                          dirty_q[bbc_pkg::Slots];
  logic [bbc_pkg::CountBits-1:0] refs   [bbc_pkg::Slots];
  logic [bbc_pkg::SlotW-1:0]     lru_q[$];
  logic [bbc_pkg::SpbW-1:0]      spb;
  bbc_pkg::rsp_t                 expected_rsp[$];

  task automatic report(string what, bbc_pkg::rsp_t got, bbc_pkg::rsp_t want);
    errors_o++;
    $display("[%0t] mismatch %s: got %p want %p", $realtime, what, got, want);
  endtask

  function automatic void push_rsp(logic [1:0] act, logic [4:0] s, logic [31:0] blk,
                                   bit cmd, logic [1:0] st, logic hit, logic last);
    bbc_pkg::rsp_t r;
    r.action = act;
    r.result_slot = s;
    r.result_block = blk;
    r.sector_address = cmd ? bbc_pkg::AddrW'(64'(blk) * 64'(spb)) : '0;
    r.sector_count = cmd ? spb : '0;
    r.status = st;
    r.hit = hit;
    r.last = last;
    expected_rsp.push_back(r);
  endfunction

  function automatic void lru_drop(int s);
    foreach (lru_q[i]) if (32'(lru_q[i]) == s) begin
      lru_q.delete(i);
      return;
    end
  endfunction

  function automatic void sync_slots(logic [31:0] mask, ref bit bad);
    for (int i = 0; i < bbc_pkg::Slots; i++) begin
      if (!dirty_q[i]) continue;
      if (mask[i]) begin
        push_rsp(bbc_pkg::ActWriteback, 5'(i), tags[i], 1, bbc_pkg::StatStorage, 0, 0);
        bad = 1;
      end else begin
        push_rsp(bbc_pkg::ActWriteback, 5'(i), tags[i], 1, bbc_pkg::StatOk, 0, 0);
        dirty_q[i] = 0;
      end
    end
  endfunction

  function automatic void predict_request(bbc_pkg::req_t rq);
    int victim;
    bit found;
    bit bad;
    victim = 0;
    found = 0;
    bad = 0;
    case (rq.kind)
      bbc_pkg::KindAcquire: begin
        for (int i = 0; i < bbc_pkg::Slots; i++)
          if (valid_q[i] && tags[i] == rq.block_number) begin
            if (refs[i] == 0) lru_drop(i);
            if (refs[i] != '1) refs[i]++;
            push_rsp(bbc_pkg::ActComplete, 5'(i), rq.block_number, 0, bbc_pkg::StatOk, 1, 1);
            return;
          end
        foreach (lru_q[i]) begin
          int c;
          c = lru_q[i];
          if (!dirty_q[c]) begin
            victim = c; found = 1; break;
          end
          if (rq.writeback_fail_mask[c]) begin
            push_rsp(bbc_pkg::ActWriteback, 5'(c), tags[c], 1, bbc_pkg::StatStorage, 0, 0);
          end else begin
            push_rsp(bbc_pkg::ActWriteback, 5'(c), tags[c], 1, bbc_pkg::StatOk, 0, 0);
            dirty_q[c] = 0; victim = c; found = 1; break;
          end
        end
        if (!found) begin
          push_rsp(bbc_pkg::ActComplete, 0, rq.block_number, 0, bbc_pkg::StatNoBuf, 0, 1);
          return;
        end
        lru_drop(victim);
        valid_q[victim] = 0;
        dirty_q[victim] = 0;
        push_rsp(bbc_pkg::ActFetch, 5'(victim), rq.block_number, 1,
                 rq.fetch_fail ? bbc_pkg::StatStorage : bbc_pkg::StatOk, 0, 0);
        if (rq.fetch_fail) begin
          lru_q.push_back(bbc_pkg::SlotW'(victim));
          push_rsp(bbc_pkg::ActComplete, 5'(victim), rq.block_number, 0,
                   bbc_pkg::StatStorage, 0, 1);
          return;
        end
        tags[victim] = rq.block_number;
        valid_q[victim] = 1;
        refs[victim] = 1;
        push_rsp(bbc_pkg::ActComplete, 5'(victim), rq.block_number, 0, bbc_pkg::StatOk, 0, 1);
      end
      bbc_pkg::KindDirty, bbc_pkg::KindRelease: begin
        if (rq.kind == bbc_pkg::KindDirty) begin
          if (valid_q[rq.slot]) dirty_q[rq.slot] = 1;
        end else if (refs[rq.slot] != 0) begin
          refs[rq.slot]--;
          if (refs[rq.slot] == 0) lru_q.push_back(rq.slot);
        end
        push_rsp(bbc_pkg::ActComplete, rq.slot, tags[rq.slot], 0, bbc_pkg::StatOk, 0, 1);
      end
      bbc_pkg::KindSync, bbc_pkg::KindDrop: begin
        sync_slots(rq.writeback_fail_mask, bad);
        if (rq.kind == bbc_pkg::KindDrop)
          for (int i = 0; i < bbc_pkg::Slots; i++) if (refs[i] == 0) begin
            valid_q[i] = 0; dirty_q[i] = 0; tags[i] = '0;
          end
        push_rsp(bbc_pkg::ActComplete, 0, 0, 0,
                 bad ? bbc_pkg::StatStorage : bbc_pkg::StatOk, 0, 1);
      end
      default: ;  // unknown kinds produce nothing
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bbc_pkg::Slots; i++) begin
        tags[i] = '0; valid_q[i] = 0; dirty_q[i] = 0; refs[i] = '0;
      end
      lru_q.delete();
      for (int i = 0; i < bbc_pkg::Slots; i++) lru_q.push_back(bbc_pkg::SlotW'(i));
      spb = bbc_pkg::SpbReset;
      expected_rsp.delete();
      errors_o = 0;
      results_o = 0;
      pending_o = 0;
    end else begin
      if (rsp_fire_i) begin
        results_o++;
        if (expected_rsp.size() == 0) begin
          report("unexpected result", rsp_i, '0);
        end else begin
          bbc_pkg::rsp_t want;
          want = expected_rsp.pop_front();
          if (rsp_i.action !== want.action) report("action", rsp_i, want);
          else if (rsp_i.result_slot !== want.result_slot) report("slot", rsp_i, want);
          else if (rsp_i.result_block !== want.result_block) report("block", rsp_i, want);
          else if (rsp_i.sector_address !== want.sector_address) report("addr", rsp_i, want);
          else if (rsp_i.sector_count !== want.sector_count) report("count", rsp_i, want);
          else if (rsp_i.status !== want.status) report("status", rsp_i, want);
          else if (rsp_i.hit !== want.hit) report("hit", rsp_i, want);
          else if (rsp_i.last !== want.last) report("last", rsp_i, want);
        end
      end
      if (req_fire_i) predict_request(req_i);
      if (cfg_we_i) spb = cfg_wdata_i;
      pending_o = expected_rsp.size();
    end
  end
endmodule

### tb/block_buffer_cache_lru_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_buffer_cache_lru_core_tb: regression bench for the buffer cache core
// Directed corner requests, then random phases per block size, random stalls.
// ----------------------------------------------------------------------------
module block_buffer_cache_lru_core_tb;

  localparam int StallLimit = 20000;
  localparam int PhaseItems = 35;

  logic                     clk_i = 0;
  logic                     rst_ni = 0;
  logic                     cfg_we_i = 0;
  logic [bbc_pkg::SpbW-1:0] cfg_wdata_i = '0;
  int                       errors, pending, results, idle_cycles, sent;
  bit                       hold_rsp;
  logic [31:0]              hot_blocks[8];

  bbc_if #(.payload_t(bbc_pkg::req_t)) req_if ();
  bbc_if #(.payload_t(bbc_pkg::rsp_t)) rsp_if ();

  block_buffer_cache_lru_core DUT (
    .clk_i, .rst_ni, .req_if(req_if.sink), .rsp_if(rsp_if.source), .cfg_we_i, .cfg_wdata_i
  );

  block_buffer_cache_lru_checker u_checker (
    .clk_i, .rst_ni,
    .req_fire_i(req_if.valid && req_if.ready), .req_i(req_if.payload),
    .rsp_fire_i(rsp_if.valid && rsp_if.ready), .rsp_i(rsp_if.payload),
    .cfg_we_i, .cfg_wdata_i, .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  initial begin
    req_if.valid = 0;
    req_if.payload = '0;
    rsp_if.ready = 0;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_rsp) begin
        rsp_if.ready <= 0;
        repeat (400) @(posedge clk_i);
        hold_rsp = 0;
      end else if (rsp_if.ready && !rsp_if.valid) begin
        rsp_if.ready <= 1;
      end else begin
        int g;
        g = gap_len();
        if (g > 0) begin
          rsp_if.ready <= 0;
          repeat (g) @(posedge clk_i);
        end
        rsp_if.ready <= 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("timeout waiting on the core");
      $display("block_buffer_cache_lru_core regression: fail");
      $finish;
    end
  end

  task automatic send(bbc_pkg::req_t rq);
    int g;
    g = gap_len();
    if (g > 0) begin
      req_if.valid <= 0;
      repeat (g) @(posedge clk_i);
    end
    req_if.valid <= 1;
    req_if.payload <= rq;
    do @(posedge clk_i); while (!req_if.ready);
    sent++;
  endtask

  // waits for a clock edge so the last accepted request is already predicted
  task automatic drain_and_config(logic [bbc_pkg::SpbW-1:0] v);
    req_if.valid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  function automatic bbc_pkg::req_t rand_req();
    logic [31:0] mask;
    int p;
    p = $urandom_range(0, 99);
    mask = ($urandom_range(0, 3) == 0) ? $urandom : '0;
    if (p < 40)
      return bbc_tb_pkg::make_req(bbc_pkg::KindAcquire,
                                  ($urandom_range(0, 3) == 0) ? $urandom
                                  : hot_blocks[$urandom_range(0, 7)],
                                  5'($urandom), mask, $urandom_range(0, 9) == 0);
    if (p < 60)
      return bbc_tb_pkg::make_req(bbc_pkg::KindDirty, $urandom, 5'($urandom), $urandom,
                                  1'($urandom));
    if (p < 88)
      return bbc_tb_pkg::make_req(bbc_pkg::KindRelease, $urandom, 5'($urandom), $urandom,
                                  1'($urandom));
    if (p < 93)
      return bbc_tb_pkg::make_req(bbc_pkg::KindSync, $urandom, 5'($urandom), mask,
                                  1'($urandom));
    if (p < 97)
      return bbc_tb_pkg::make_req(bbc_pkg::KindDrop, $urandom, 5'($urandom), mask,
                                  1'($urandom));
    return bbc_tb_pkg::make_req(3'($urandom_range(5, 7)), $urandom, 5'($urandom), $urandom,
                                1'($urandom));
  endfunction

  initial begin
    logic [bbc_pkg::SpbW-1:0] settings[4];
    settings = '{4'd1, 4'd8, 4'd15, 4'd0};
    sent = 0;
    hold_rsp = 0;
    foreach (hot_blocks[i]) hot_blocks[i] = $urandom;
    hot_blocks[0] = '0;
    hot_blocks[1] = '1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: extremes, fail paths, saturation guard, out-of-range ops
    send(bbc_tb_pkg::make_req(bbc_pkg::KindAcquire, 32'hFFFF_FFFF, 0, 0, 0));
    send(bbc_tb_pkg::make_req(bbc_pkg::KindAcquire, 32'h0, 0, 0, 1));       // fetch failure
    send(bbc_tb_pkg::make_req(bbc_pkg::KindAcquire, 32'h0, 0, 0, 0));
    send(bbc_tb_pkg::make_req(bbc_pkg::KindAcquire, 32'hFFFF_FFFF, 0, 0, 0)); // hit
    send(bbc_tb_pkg::make_req(bbc_pkg::KindDirty, 0, 0, 0, 0));
    send(bbc_tb_pkg::make_req(bbc_pkg::KindDirty, 0, 5'd31, 0, 0));         // invalid slot
    send(bbc_tb_pkg::make_req(bbc_pkg::KindRelease, 0, 5'd31, 0, 0));       // count zero
    send(bbc_tb_pkg::make_req(bbc_pkg::KindRelease, 0, 0, 0, 0));
    send(bbc_tb_pkg::make_req(bbc_pkg::KindRelease, 0, 0, 0, 0));
    send(bbc_tb_pkg::make_req(bbc_pkg::KindSync, 0, 0, 32'h1, 0));          // write-back fails
    send(bbc_tb_pkg::make_req(bbc_pkg::KindSync, 0, 0, 32'hFFFF_FFFF, 0));
    send(bbc_tb_pkg::make_req(bbc_pkg::KindAcquire, 32'h1234_5678, 0, 32'hFFFF_FFFF, 0));
    send(bbc_tb_pkg::make_req(bbc_pkg::KindDrop, 0, 0, 32'hFFFF_FFFF, 0));  // drop, failure
    send(bbc_tb_pkg::make_req(bbc_pkg::KindSync, 0, 0, 0, 0));
    send(bbc_tb_pkg::make_req(3'd7, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF, 1));
    send(bbc_tb_pkg::make_req(3'd5, 0, 0, 0, 0));
    // fill every slot so a miss finds an empty LRU list
    for (int i = 0; i < bbc_pkg::Slots; i++)
      send(bbc_tb_pkg::make_req(bbc_pkg::KindAcquire, 32'h100 + 32'(i), 0, 0, 0));
    send(bbc_tb_pkg::make_req(bbc_pkg::KindAcquire, 32'hDEAD_BEEF, 0, 0, 0));
    for (int i = 0; i < bbc_pkg::Slots; i++)
      send(bbc_tb_pkg::make_req(bbc_pkg::KindRelease, 0, 5'(i), 0, 0));

    foreach (settings[ph]) begin
      drain_and_config(settings[ph]);
      if (ph == 1) hold_rsp = 1;
      for (int n = 0; n < PhaseItems; n++) send(rand_req());
    end
    // bring the cache to a clean state before the last writes to the register
    send(bbc_tb_pkg::make_req(bbc_pkg::KindDrop, 0, 0, 0, 0));
    drain_and_config(bbc_pkg::SpbReset);
    for (int n = 0; n < 10; n++) send(rand_req());

    req_if.valid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("sent %0d requests, checked %0d results over 6 block-size settings", sent, results);
    if (errors == 0) $display("block_buffer_cache_lru_core regression: pass");
    else $display("block_buffer_cache_lru_core regression: fail");
    $finish;
  end
endmodule
